### hw/rtl/abe_pkg.sv
// abe_pkg: shared types, character codes and helpers for the expression evaluator
// used by abe_front, abe_queue, abe_back and ascii_binary_expression_evaluator_unit
// no dependencies
package abe_pkg;

	// width of one result value on the output port
	localparam int VALUE_BITS = 32;

	// number of finished expressions the queue between front and back can hold
	localparam int QUEUE_DEPTH = 2;

	// ascii codes the parser looks for
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_MOD = 2'd3
	} abe_op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_MOD_ZERO    = 2'd1,
		ST_NON_DIGIT   = 2'd2,
		ST_NO_OPERATOR = 2'd3
	} abe_status_t;

	// control part of one queued expression
	typedef struct packed {
		abe_op_t     op;
		abe_status_t status;
	} job_ctrl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_HOLD
	} back_state_t;

	// operator character that belongs to an operation select
	function automatic logic [7:0] op_char(input abe_op_t op);
		logic [7:0] c;
		case (op)
			OP_ADD:  c = CH_PLUS;
			OP_SUB:  c = CH_MINUS;
			OP_MUL:  c = CH_STAR;
			OP_MOD:  c = CH_PCT;
			default: c = CH_PLUS;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/abe_front.sv
// abe_front: character parser, one item per cycle while accept is high, builds the operands of an expression
// depends on abe_pkg; pushes one job per expression into abe_queue
module abe_front import abe_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           action,
	input  logic [7:0]           character,
	input  logic                 last,
	output logic                 push,
	output job_ctrl_t            job_ctrl,
	output logic [WORD_BITS-1:0] job_a,
	output logic [WORD_BITS-1:0] job_b
);

	logic                 right_q, start_q, neg_q, nondigit_q;
	logic [WORD_BITS-1:0] acc_q, left_q;

	logic                 right_nxt, start_nxt, neg_nxt, nondigit_nxt;
	logic [WORD_BITS-1:0] acc_nxt, left_nxt;
	logic                 pos_zero, is_digit;
	abe_op_t              op;

	assign op       = abe_op_t'(action);
	assign pos_zero = start_q && !right_q;
	assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);

	// classify the character and work out the next parse state
	always_comb begin
		right_nxt    = right_q;
		start_nxt    = start_q;
		neg_nxt      = neg_q;
		nondigit_nxt = nondigit_q;
		acc_nxt      = acc_q;
		left_nxt     = left_q;
		if (!right_q && !pos_zero && character == op_char(op)) begin
			left_nxt  = neg_q ? (-acc_q) : acc_q;
			acc_nxt   = '0;
			neg_nxt   = 1'b0;
			start_nxt = 1'b1;
			right_nxt = 1'b1;
		end else if (start_q && character == CH_MINUS) begin
			neg_nxt   = 1'b1;
			start_nxt = 1'b0;
		end else if (is_digit) begin
			// acc * 10 + digit as two shifts and adds
			acc_nxt   = (acc_q << 3) + (acc_q << 1)
				+ {{(WORD_BITS-4){1'b0}}, character[3:0]};
			start_nxt = 1'b0;
		end else begin
			nondigit_nxt = 1'b1;
			start_nxt    = 1'b0;
		end
	end

	// job handed to the queue on the last character
	always_comb begin
		job_ctrl.op = op;
		if (nondigit_nxt) begin
			job_ctrl.status = ST_NON_DIGIT;
		end else if (!right_nxt) begin
			job_ctrl.status = ST_NO_OPERATOR;
		end else begin
			job_ctrl.status = ST_OK;
		end
		job_a = left_nxt;
		job_b = neg_nxt ? (-acc_nxt) : acc_nxt;
	end

	assign push = accept && last;

	// parse state, back to the start after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q    <= 1'b0;
			start_q    <= 1'b1;
			neg_q      <= 1'b0;
			nondigit_q <= 1'b0;
			acc_q      <= '0;
			left_q     <= '0;
		end else if (accept) begin
			if (last) begin
				right_q    <= 1'b0;
				start_q    <= 1'b1;
				neg_q      <= 1'b0;
				nondigit_q <= 1'b0;
				acc_q      <= '0;
				left_q     <= '0;
			end else begin
				right_q    <= right_nxt;
				start_q    <= start_nxt;
				neg_q      <= neg_nxt;
				nondigit_q <= nondigit_nxt;
				acc_q      <= acc_nxt;
				left_q     <= left_nxt;
			end
		end
	end

endmodule

### hw/rtl/abe_queue.sv
// abe_queue: short first-in first-out buffer of parsed expressions
// depends on abe_pkg for its depth
module abe_queue import abe_pkg::*; #(
	parameter int WIDTH = 68
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    entry_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wptr_q, rptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full  = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= (wptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rptr_q <= (rptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/abe_back.sv
// abe_back: carries out one queued expression and holds the result item
// depends on abe_pkg; iterative shift-add multiply and restoring remainder unit
module abe_back import abe_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  job_ctrl_t             job_ctrl,
	input  logic [WORD_BITS-1:0]  job_a,
	input  logic [WORD_BITS-1:0]  job_b,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] value,
	output logic [1:0]            status
);

	localparam int CNT_BITS = $clog2(WORD_BITS);

	back_state_t          state_q, state_nxt;
	logic [WORD_BITS-1:0] x_q, y_q, r_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 is_mod_q, neg_q;
	abe_status_t          st_q;
	logic [WORD_BITS-1:0] res_q;
	logic                 out_valid_q;
	abe_status_t          out_status_q;
	logic [VALUE_BITS-1:0] out_value_q;

	logic                 slot_free, run_done;
	logic                 a_neg, b_neg;
	logic [WORD_BITS-1:0] a_mag, b_mag;
	logic [WORD_BITS-1:0] rem_sh, step_r;

	assign slot_free = !out_valid_q || !out_stall;
	assign run_done  = (cnt_q == CNT_BITS'(WORD_BITS - 1));
	assign pop       = (state_q == BK_IDLE) && job_valid;

	assign a_neg = job_a[WORD_BITS-1];
	assign b_neg = job_b[WORD_BITS-1];
	assign a_mag = a_neg ? (-job_a) : job_a;
	assign b_mag = b_neg ? (-job_b) : job_b;

	// one step of the shared unit: add for multiply, compare and subtract for remainder
	always_comb begin
		rem_sh = {r_q[WORD_BITS-2:0], x_q[WORD_BITS-1]};
		if (is_mod_q) begin
			step_r = (rem_sh >= y_q) ? (rem_sh - y_q) : rem_sh;
		end else begin
			step_r = y_q[0] ? (r_q + x_q) : r_q;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					if (job_ctrl.status == ST_OK
						&& (job_ctrl.op == OP_MUL
						|| (job_ctrl.op == OP_MOD && job_b != '0))) begin
						state_nxt = BK_RUN;
					end else begin
						state_nxt = BK_HOLD;
					end
				end
			end
			BK_RUN: begin
				if (run_done) begin
					state_nxt = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (slot_free) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					cnt_q    <= '0;
					r_q      <= '0;
					is_mod_q <= (job_ctrl.op == OP_MOD);
					neg_q    <= a_neg;
					x_q      <= (job_ctrl.op == OP_MOD) ? a_mag : job_a;
					y_q      <= (job_ctrl.op == OP_MOD) ? b_mag : job_b;
					if (job_ctrl.status != ST_OK) begin
						st_q  <= job_ctrl.status;
						res_q <= '0;
					end else begin
						case (job_ctrl.op)
							OP_ADD: begin
								st_q  <= ST_OK;
								res_q <= job_a + job_b;
							end
							OP_SUB: begin
								st_q  <= ST_OK;
								res_q <= job_a - job_b;
							end
							OP_MOD: begin
								st_q  <= (job_b == '0) ? ST_MOD_ZERO : ST_OK;
								res_q <= '0;
							end
							default: begin
								st_q  <= ST_OK;
								res_q <= '0;
							end
						endcase
					end
				end
			end
			BK_RUN: begin
				r_q   <= step_r;
				cnt_q <= cnt_q + 1'b1;
				x_q   <= x_q << 1;
				if (!is_mod_q) begin
					y_q <= y_q >> 1;
				end
				if (run_done) begin
					if (is_mod_q && neg_q) begin
						res_q <= -step_r;
					end else begin
						res_q <= step_r;
					end
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// output register, loads while empty or while its item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= (state_q == BK_HOLD);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_HOLD && slot_free) begin
			out_value_q  <= VALUE_BITS'(signed'(res_q));
			out_status_q <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = out_value_q;
	assign status    = out_status_q;

endmodule

### hw/rtl/ascii_binary_expression_evaluator_unit.sv
// ascii_binary_expression_evaluator_unit: top level of the ascii expression evaluator
// depends on abe_pkg, abe_front, abe_queue and abe_back
//
//   channel   handshake           fields
//   input     in_valid/in_stall   action[1:0], character[7:0], last
//   output    out_valid/out_stall value[31:0] signed, status[1:0]
//
// the front takes one character item per cycle; in_stall rises only while the
// expression queue (two entries) is full
// add and subtract are computed as the job is taken from the queue; multiply and modulo
// run one step per cycle through the shared shift-add unit
// no clearing pass: the block accepts items in the first cycle after reset
// a waiting result sits in the output register while the next job runs
module ascii_binary_expression_evaluator_unit import abe_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            action,
	input  logic [7:0]            character,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] value,
	output logic [1:0]            status
);

	localparam int JOB_BITS = $bits(job_ctrl_t) + 2 * WORD_BITS;

	logic                 accept, push, pop, full, empty;
	job_ctrl_t            f_ctrl, b_ctrl;
	logic [WORD_BITS-1:0] f_a, f_b, b_a, b_b;
	logic [JOB_BITS-1:0]  q_rdata;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	// character parser
	abe_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.character (character),
		.last      (last),
		.push      (push),
		.job_ctrl  (f_ctrl),
		.job_a     (f_a),
		.job_b     (f_b)
	);

	// parsed expressions waiting for the back end
	abe_queue #(
		.WIDTH (JOB_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_ctrl, f_a, f_b}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (full),
		.empty  (empty)
	);

	assign {b_ctrl, b_a, b_b} = q_rdata;

	// arithmetic and result item
	abe_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!empty),
		.job_ctrl  (b_ctrl),
		.job_a     (b_a),
		.job_b     (b_b),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

endmodule

### verif/tb_ascii_binary_expression_evaluator_unit.sv
// tb_ascii_binary_expression_evaluator_unit: self-checking testbench for the ascii expression evaluator
// depends on abe_pkg and ascii_binary_expression_evaluator_unit
// feeds expressions one character per item, predicts each result and checks value and status
module tb_ascii_binary_expression_evaluator_unit;
	import abe_pkg::*;

	localparam int WORD_BITS = 32;
	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 9;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int LONG_HOLD = 200;
	localparam int RUN_LIMIT = 12 * 300000;

	// operator character for each operation, indexed by the operation code
	localparam logic [3:0][7:0] OPER_CHARS = {CH_PCT, CH_STAR, CH_MINUS, CH_PLUS};

	typedef struct packed {
		abe_op_t    op;
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct {
		logic [31:0] value;
		abe_status_t status;
	} expr_result_t;

	// parser model and queue of results still owed by the block
	class expr_scoreboard;
		bit          in_right;
		bit          at_start;
		bit          negative;
		bit [31:0]   acc;
		bit [31:0]   left;
		abe_status_t err;
		expr_result_t owed_q[$];
		int          errors;

		function new();
			errors = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			in_right = 1'b0;
			at_start = 1'b1;
			negative = 1'b0;
			acc = '0;
			left = '0;
			err = ST_OK;
		endfunction

		function bit [31:0] operand_value();
			return negative ? -acc : acc;
		endfunction

		// truncating remainder, sign follows the dividend
		function bit [31:0] trunc_mod(bit [31:0] a, bit [31:0] b);
			bit [31:0] ma;
			bit [31:0] mb;
			bit [31:0] r;
			ma = a[31] ? -a : a;
			mb = b[31] ? -b : b;
			r = ma % mb;
			return a[31] ? -r : r;
		endfunction

		function void note_char(abe_op_t op, bit [7:0] ch, bit last_char);
			bit           at_zero;
			bit [31:0]    rhs;
			expr_result_t r;
			at_zero = at_start && !in_right;
			// operator split, sign, digit or bad character
			if (!in_right && !at_zero && ch == OPER_CHARS[op]) begin
				left = operand_value();
				acc = '0;
				negative = 1'b0;
				at_start = 1'b1;
				in_right = 1'b1;
			end else if (at_start && ch == CH_MINUS) begin
				negative = 1'b1;
				at_start = 1'b0;
			end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
				acc = acc * 10 + 32'(ch - CH_ZERO);
				at_start = 1'b0;
			end else begin
				err = ST_NON_DIGIT;
				at_start = 1'b0;
			end
			if (!last_char)
				return;
			// closing character: work out the result
			r.value = '0;
			if (err != ST_OK) begin
				r.status = err;
			end else if (!in_right) begin
				r.status = ST_NO_OPERATOR;
			end else begin
				rhs = operand_value();
				r.status = ST_OK;
				case (op)
					OP_ADD: r.value = left + rhs;
					OP_SUB: r.value = left - rhs;
					OP_MUL: r.value = left * rhs;
					default: begin
						if (rhs == 0)
							r.status = ST_MOD_ZERO;
						else
							r.value = trunc_mod(left, rhs);
					end
				endcase
			end
			if (r.status != ST_OK)
				r.value = '0;
			owed_q.push_back(r);
			clear_parse();
		endfunction

		function void check_result(logic [31:0] value, logic [1:0] status);
			expr_result_t r;
			if (owed_q.size() == 0) begin
				$error("result with none owed: value %0d status %0d", $signed(value), status);
				errors++;
				return;
			end
			r = owed_q.pop_front();
			if (value !== r.value) begin
				$error("value: expected %0d, actual %0d", $signed(r.value), $signed(value));
				errors++;
			end
			if (status !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, status);
				errors++;
			end
		endfunction

		function int owed();
			return owed_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	abe_op_t               action = OP_ADD;
	logic [7:0]            character = 8'h00;
	logic                  last = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VALUE_BITS-1:0] value;
	logic [1:0]            status;

	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   chars_sent = 0;

	char_item_t     expr_q[$];
	expr_scoreboard sb = new();

	ascii_binary_expression_evaluator_unit #(
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.character(character),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status)
	);

	always #CLK_HALF clk = ~clk;

	// accepted input items feed the model
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_char(action, character, last);
	end

	// accepted results are checked against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(value, status);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		#(RUN_LIMIT);
		$display("tb_ascii_binary_expression_evaluator_unit: FAIL");
		$finish;
	end

	function automatic void push_char(abe_op_t op, logic [7:0] ch);
		expr_q.push_back('{op, ch, 1'b0});
	endfunction

	function automatic void push_text(abe_op_t op, string s);
		for (int i = 0; i < s.len(); i++)
			push_char(op, s[i]);
	endfunction

	// optional sign, then a digit string that is empty, short, long or a corner value
	function automatic void push_operand(abe_op_t op);
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 30)
			push_char(op, CH_MINUS);
		if (pick < 20) begin
			case ($urandom_range(0, 5))
				0: push_text(op, "0");
				1: push_text(op, "1");
				2: push_text(op, "2147483648");
				3: push_text(op, "2147483647");
				4: push_text(op, "4294967295");
				default: push_text(op, "65536");
			endcase
			return;
		end
		if (pick < 35)
			n = 0;
		else if (pick < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(4, 12);
		for (int i = 0; i < n; i++)
			push_char(op, CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// mostly well-formed expressions, some broken or pure noise
	function automatic void build_random_expr();
		abe_op_t    op;
		int         kind;
		int         n;
		char_item_t junk;
		op = abe_op_t'($urandom_range(0, 3));
		kind = $urandom_range(0, 99);
		if (kind < 90) begin
			push_operand(op);
			if (kind < 85)
				push_char(op, OPER_CHARS[op]);
			push_operand(op);
			if (kind >= 75 && kind < 85) begin
				junk = '{op, 8'($urandom_range(0, 255)), 1'b0};
				expr_q.insert($urandom_range(0, expr_q.size()), junk);
			end
		end else begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				push_char(op, 8'($urandom_range(0, 255)));
		end
		if (expr_q.size() == 0)
			push_char(op, OPER_CHARS[op]);
		// sometimes the select wanders before the closing character
		if ($urandom_range(0, 99) < 10) begin
			for (int i = 0; i < expr_q.size() - 1; i++)
				expr_q[i].op = abe_op_t'($urandom_range(0, 3));
		end
	endfunction

	task automatic send_char(char_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.op;
		character <= it.ch;
		last <= it.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	// mark the closing character and send the whole expression
	task automatic send_expr();
		expr_q[expr_q.size() - 1].last = 1'b1;
		foreach (expr_q[i])
			send_char(expr_q[i]);
		expr_q.delete();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed expressions under the first idling mix
		send_idle_pct = 10;
		recv_idle_pct = 53;
		push_text(OP_ADD, "-+");
		send_expr();
		push_char(OP_ADD, CH_PLUS);
		push_char(OP_ADD, 8'h00);
		send_expr();
		push_text(OP_SUB, "5");
		send_expr();
		push_text(OP_MOD, "7%0");
		send_expr();
		push_text(OP_MOD, "-7%-3");
		send_expr();
		push_text(OP_MOD, "-2147483648%-1");
		send_expr();
		push_text(OP_MUL, "12");
		push_text(OP_SUB, "-");
		push_text(OP_MUL, "3");
		send_expr();

		// random expressions in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 53;
				end
				1: begin
					send_idle_pct = 53;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_req <= 1'b1;
				end
			endcase
			chars_sent = 0;
			while (chars_sent < ITEMS_PER_PHASE) begin
				build_random_expr();
				send_expr();
			end
		end
		in_valid <= 1'b0;
		last <= 1'b0;

		// drain, then allow for a late result
		while (sb.owed() != 0)
			@(posedge clk);
		repeat (WORD_BITS + 16) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_ascii_binary_expression_evaluator_unit: PASS");
		else
			$display("tb_ascii_binary_expression_evaluator_unit: FAIL");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/abe_pkg.sv
hw/rtl/abe_front.sv
hw/rtl/abe_queue.sv
hw/rtl/abe_back.sv
hw/rtl/ascii_binary_expression_evaluator_unit.sv
verif/tb_ascii_binary_expression_evaluator_unit.sv
